>>> src/bll_pkg.sv
// Shared types and constants for the binary-lifting lowest-common-ancestor block.
package bll_pkg;

    // Width of a node field on the ports.
    localparam int FIELD_W = 10;
    // Width of the step/level index carried in a datapath command (covers 32 levels).
    localparam int STEP_W = 5;

    // Action codes of an input item.
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_ADD_RD,
        ST_ADD_FIRST,
        ST_ADD_STEP,
        ST_ADD_WR,
        ST_Q_RD,
        ST_Q_SWAP,
        ST_Q_LIFT,
        ST_Q_CHECK,
        ST_Q_CLIMB,
        ST_Q_FIN,
        ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_CLEAR,
        DP_REDUCE,
        DP_ADD_RD,
        DP_ADD_FIRST,
        DP_ADD_STEP,
        DP_ADD_WR,
        DP_Q_RD,
        DP_Q_SWAP,
        DP_Q_LIFT,
        DP_Q_CHECK,
        DP_Q_CLIMB,
        DP_Q_FIN,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op              op;
        logic [STEP_W-1:0]   step;
    } t_dp_cmd;

    typedef struct packed {
        logic node_zero;
        logic same;
        logic clr_last;
    } t_dp_stat;

endpackage

>>> src/bll_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module bll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> src/bll_dp.sv
// Datapath: node table RAM (depth plus ancestor levels per row), index reduction, walk registers.
module bll_dp #(
    parameter int NODE_COUNT  = 1024,
    parameter int JUMP_LEVELS = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bll_pkg::FIELD_W-1:0]   i_node_a,
    input  logic [bll_pkg::FIELD_W-1:0]   i_node_b,
    input  bll_pkg::t_dp_cmd              i_cmd,
    output bll_pkg::t_dp_stat             o_stat,
    output logic [bll_pkg::FIELD_W-1:0]   o_result
);

    localparam int NW = $clog2(NODE_COUNT);
    localparam int LW = $clog2(JUMP_LEVELS);
    localparam int RW = NW * (JUMP_LEVELS + 1);
    localparam int FW = bll_pkg::FIELD_W;
    localparam logic [NW-1:0] DepthMax = NW'(NODE_COUNT - 1);

    // Row layout: depth in the low field, level j at field j + 1.
    function automatic logic [NW-1:0] f_lev(input logic [RW-1:0] row, input logic [LW-1:0] k);
        f_lev = row[NW * (int'(k) + 1) +: NW];
    endfunction

    logic [FW-1:0] r_ra, n_ra, r_rb, n_rb;
    logic [NW-1:0] r_x, n_x, r_y, n_y, r_ca, n_ca, r_cb, n_cb;
    logic [NW-1:0] r_dy, n_dy, r_d, n_d, r_ans, n_ans, r_clr, n_clr;
    logic [RW-1:0] r_xrow, n_xrow, r_yrow, n_yrow;
    logic          r_pend, n_pend, r_take2, n_take2;
    logic [NW-1:0] r_lev [JUMP_LEVELS];
    logic [NW-1:0] n_lev [JUMP_LEVELS];
    logic [FW-1:0] r_result, n_result;

    logic [NW-1:0] w_ia, w_ib;
    logic [RW-1:0] w_rd_a, w_rd_b;
    logic          w_take_x, w_take_y;
    logic [NW-1:0] w_cur_x, w_cur_y;
    logic [RW-1:0] w_cur_x_row, w_cur_y_row;
    logic [LW-1:0] w_k, w_km1;
    logic [31:0]   w_lim;
    logic [NW-1:0] w_dnew, w_lev1, w_levk, w_prev, w_up_x, w_up_y;
    logic          w_we;
    logic [NW-1:0] w_waddr, w_raddr_a, w_raddr_b;
    logic [RW-1:0] w_wdata, w_wr_row;

    bll_ram #(
        .WIDTH (RW),
        .DEPTH (NODE_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    // Node indices after reduction into the table range.
    assign w_ia  = NW'(r_ra);
    assign w_ib  = NW'(r_rb);
    assign w_k   = i_cmd.step[LW-1:0];
    assign w_km1 = w_k - LW'(1);
    assign w_lim = 32'(NODE_COUNT) << i_cmd.step;

    // A lift candidate is taken once its row shows it is not above the target depth.
    assign w_take_x    = (r_pend && (w_rd_a[NW-1:0] >= r_dy)) || r_take2;
    assign w_take_y    = r_take2;
    assign w_cur_x     = w_take_x ? r_ca : r_x;
    assign w_cur_x_row = w_take_x ? w_rd_a : r_xrow;
    assign w_cur_y     = w_take_y ? r_cb : r_y;
    assign w_cur_y_row = w_take_y ? w_rd_b : r_yrow;
    assign w_up_x      = f_lev(w_cur_x_row, w_k);
    assign w_up_y      = f_lev(w_cur_y_row, w_k);

    // Saturating depth of the added node.
    assign w_dnew = (w_rd_a[NW-1:0] < DepthMax) ? (w_rd_a[NW-1:0] + NW'(1))
                                                : w_rd_a[NW-1:0];
    // Level 1 comes from the parent's row; a self-parent points back at the node.
    assign w_lev1 = (32'(w_dnew) >= 32'd2) ? ((r_y == r_x) ? r_x : f_lev(w_rd_a, '0)) : '0;
    assign w_prev = r_lev[w_km1];
    assign w_levk = ((32'd1 << w_k) <= 32'(r_d))
                  ? ((w_prev == r_x) ? r_x : f_lev(w_rd_a, w_km1)) : '0;

    always_comb begin
        w_wr_row[NW-1:0] = r_d;
        for (int j = 0; j < JUMP_LEVELS; j++) begin
            w_wr_row[NW * (j + 1) +: NW] = r_lev[j];
        end
    end

    always_comb begin
        n_ra     = r_ra;
        n_rb     = r_rb;
        n_x      = r_x;
        n_y      = r_y;
        n_ca     = r_ca;
        n_cb     = r_cb;
        n_dy     = r_dy;
        n_d      = r_d;
        n_ans    = r_ans;
        n_clr    = r_clr;
        n_xrow   = r_xrow;
        n_yrow   = r_yrow;
        n_pend   = 1'b0;
        n_take2  = 1'b0;
        n_lev    = r_lev;
        n_result = r_result;
        w_we      = 1'b0;
        w_waddr   = r_x;
        w_wdata   = w_wr_row;
        w_raddr_a = '0;
        w_raddr_b = '0;
        case (i_cmd.op)
            bll_pkg::DP_LOAD: begin
                n_ra = i_node_a;
                n_rb = i_node_b;
            end
            bll_pkg::DP_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                n_clr   = r_clr + NW'(1);
            end
            bll_pkg::DP_REDUCE: begin
                // One restoring step of the modulo per cycle.
                if (32'(r_ra) >= w_lim) begin
                    n_ra = r_ra - FW'(w_lim);
                end
                if (32'(r_rb) >= w_lim) begin
                    n_rb = r_rb - FW'(w_lim);
                end
            end
            bll_pkg::DP_ADD_RD: begin
                w_raddr_a = w_ib;
                n_x       = w_ia;
                n_y       = w_ib;
            end
            bll_pkg::DP_ADD_FIRST: begin
                n_d       = w_dnew;
                n_lev[0]  = r_y;
                n_lev[1]  = w_lev1;
                w_raddr_a = w_lev1;
            end
            bll_pkg::DP_ADD_STEP: begin
                n_lev[w_k] = w_levk;
                w_raddr_a  = w_levk;
            end
            bll_pkg::DP_ADD_WR: begin
                w_we = 1'b1;
            end
            bll_pkg::DP_Q_RD: begin
                w_raddr_a = w_ia;
                w_raddr_b = w_ib;
                n_x       = w_ia;
                n_y       = w_ib;
            end
            bll_pkg::DP_Q_SWAP: begin
                // Keep the deeper node in x.
                if (w_rd_a[NW-1:0] < w_rd_b[NW-1:0]) begin
                    n_x    = r_y;
                    n_xrow = w_rd_b;
                    n_y    = r_x;
                    n_yrow = w_rd_a;
                    n_dy   = w_rd_a[NW-1:0];
                end else begin
                    n_xrow = w_rd_a;
                    n_yrow = w_rd_b;
                    n_dy   = w_rd_b[NW-1:0];
                end
            end
            bll_pkg::DP_Q_LIFT: begin
                w_raddr_a = w_up_x;
                n_ca      = w_up_x;
                n_x       = w_cur_x;
                n_xrow    = w_cur_x_row;
                n_pend    = 1'b1;
            end
            bll_pkg::DP_Q_CHECK: begin
                n_x    = w_cur_x;
                n_xrow = w_cur_x_row;
                n_ans  = w_cur_x;
            end
            bll_pkg::DP_Q_CLIMB: begin
                w_raddr_a = w_up_x;
                w_raddr_b = w_up_y;
                n_ca      = w_up_x;
                n_cb      = w_up_y;
                n_take2   = (w_up_x != w_up_y);
                n_x       = w_cur_x;
                n_xrow    = w_cur_x_row;
                n_y       = w_cur_y;
                n_yrow    = w_cur_y_row;
            end
            bll_pkg::DP_Q_FIN: begin
                n_ans = f_lev(w_cur_x_row, '0);
            end
            bll_pkg::DP_OUT: begin
                n_result = FW'(r_ans);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_pend  <= 1'b0;
            r_take2 <= 1'b0;
        end else begin
            r_clr   <= n_clr;
            r_pend  <= n_pend;
            r_take2 <= n_take2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ra     <= n_ra;
        r_rb     <= n_rb;
        r_x      <= n_x;
        r_y      <= n_y;
        r_ca     <= n_ca;
        r_cb     <= n_cb;
        r_dy     <= n_dy;
        r_d      <= n_d;
        r_ans    <= n_ans;
        r_xrow   <= n_xrow;
        r_yrow   <= n_yrow;
        r_lev    <= n_lev;
        r_result <= n_result;
    end

    assign o_stat.node_zero = (w_ia == '0);
    assign o_stat.same      = (w_cur_x == r_y);
    assign o_stat.clr_last  = (r_clr == DepthMax);
    assign o_result         = r_result;

endmodule

>>> src/bll_ctrl.sv
// Controller: state machine that sequences clear, add and query walks over the datapath.
module bll_ctrl #(
    parameter int NODE_COUNT  = 1024,
    parameter int JUMP_LEVELS = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_action,
    input  logic               i_ready,
    input  bll_pkg::t_dp_stat  i_stat,
    output logic               o_ready,
    output logic               o_valid,
    output bll_pkg::t_dp_cmd   o_cmd
);

    localparam int SW       = bll_pkg::STEP_W;
    localparam int FieldMax = (1 << bll_pkg::FIELD_W) - 1;
    localparam int RedSteps = (NODE_COUNT > FieldMax) ? 0 : $clog2(FieldMax / NODE_COUNT + 1);

    bll_pkg::t_state r_state, n_state;
    logic [SW-1:0]   r_cnt, n_cnt;
    logic            r_act, n_act;
    logic            r_ovalid, n_ovalid;
    logic            w_out_free;

    assign w_out_free = !r_ovalid || i_ready;

    // Next state, step counter and output flag.
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_act    = r_act;
        n_ovalid = r_ovalid && !i_ready;
        case (r_state)
            bll_pkg::ST_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = bll_pkg::ST_IDLE;
                end
            end
            bll_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_act = i_action;
                    if (RedSteps > 0) begin
                        n_state = bll_pkg::ST_REDUCE;
                        n_cnt   = SW'(RedSteps - 1);
                    end else if (i_action == bll_pkg::ACT_QUERY) begin
                        n_state = bll_pkg::ST_Q_RD;
                    end else begin
                        n_state = bll_pkg::ST_ADD_RD;
                    end
                end
            end
            bll_pkg::ST_REDUCE: begin
                if (r_cnt == '0) begin
                    n_state = (r_act == bll_pkg::ACT_QUERY) ? bll_pkg::ST_Q_RD
                                                            : bll_pkg::ST_ADD_RD;
                end else begin
                    n_cnt = r_cnt - SW'(1);
                end
            end
            bll_pkg::ST_ADD_RD: begin
                n_state = i_stat.node_zero ? bll_pkg::ST_IDLE : bll_pkg::ST_ADD_FIRST;
            end
            bll_pkg::ST_ADD_FIRST: begin
                if (JUMP_LEVELS > 2) begin
                    n_state = bll_pkg::ST_ADD_STEP;
                    n_cnt   = SW'(2);
                end else begin
                    n_state = bll_pkg::ST_ADD_WR;
                end
            end
            bll_pkg::ST_ADD_STEP: begin
                if (r_cnt == SW'(JUMP_LEVELS - 1)) begin
                    n_state = bll_pkg::ST_ADD_WR;
                end else begin
                    n_cnt = r_cnt + SW'(1);
                end
            end
            bll_pkg::ST_ADD_WR: begin
                n_state = bll_pkg::ST_IDLE;
            end
            bll_pkg::ST_Q_RD: begin
                n_state = bll_pkg::ST_Q_SWAP;
            end
            bll_pkg::ST_Q_SWAP: begin
                n_state = bll_pkg::ST_Q_LIFT;
                n_cnt   = SW'(JUMP_LEVELS - 1);
            end
            bll_pkg::ST_Q_LIFT: begin
                if (r_cnt == '0) begin
                    n_state = bll_pkg::ST_Q_CHECK;
                end else begin
                    n_cnt = r_cnt - SW'(1);
                end
            end
            bll_pkg::ST_Q_CHECK: begin
                if (i_stat.same) begin
                    n_state = bll_pkg::ST_OUT;
                end else begin
                    n_state = bll_pkg::ST_Q_CLIMB;
                    n_cnt   = SW'(JUMP_LEVELS - 1);
                end
            end
            bll_pkg::ST_Q_CLIMB: begin
                if (r_cnt == '0) begin
                    n_state = bll_pkg::ST_Q_FIN;
                end else begin
                    n_cnt = r_cnt - SW'(1);
                end
            end
            bll_pkg::ST_Q_FIN: begin
                n_state = bll_pkg::ST_OUT;
            end
            bll_pkg::ST_OUT: begin
                if (w_out_free) begin
                    n_state  = bll_pkg::ST_IDLE;
                    n_ovalid = 1'b1;
                end
            end
            default: begin
                n_state = bll_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath commands and the input handshake.
    always_comb begin
        o_ready    = 1'b0;
        o_cmd.op   = bll_pkg::DP_NOP;
        o_cmd.step = r_cnt;
        case (r_state)
            bll_pkg::ST_CLEAR:     o_cmd.op = bll_pkg::DP_CLEAR;
            bll_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.op = bll_pkg::DP_LOAD;
                end
            end
            bll_pkg::ST_REDUCE:    o_cmd.op = bll_pkg::DP_REDUCE;
            bll_pkg::ST_ADD_RD:    o_cmd.op = bll_pkg::DP_ADD_RD;
            bll_pkg::ST_ADD_FIRST: o_cmd.op = bll_pkg::DP_ADD_FIRST;
            bll_pkg::ST_ADD_STEP:  o_cmd.op = bll_pkg::DP_ADD_STEP;
            bll_pkg::ST_ADD_WR:    o_cmd.op = bll_pkg::DP_ADD_WR;
            bll_pkg::ST_Q_RD:      o_cmd.op = bll_pkg::DP_Q_RD;
            bll_pkg::ST_Q_SWAP:    o_cmd.op = bll_pkg::DP_Q_SWAP;
            bll_pkg::ST_Q_LIFT:    o_cmd.op = bll_pkg::DP_Q_LIFT;
            bll_pkg::ST_Q_CHECK:   o_cmd.op = bll_pkg::DP_Q_CHECK;
            bll_pkg::ST_Q_CLIMB:   o_cmd.op = bll_pkg::DP_Q_CLIMB;
            bll_pkg::ST_Q_FIN:     o_cmd.op = bll_pkg::DP_Q_FIN;
            bll_pkg::ST_OUT: begin
                if (w_out_free) begin
                    o_cmd.op = bll_pkg::DP_OUT;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bll_pkg::ST_CLEAR;
            r_cnt    <= '0;
            r_act    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_act    <= n_act;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid = r_ovalid;

endmodule

>>> src/binary_lifting_lca.sv
// Top level of the binary-lifting lowest-common-ancestor block.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  input    | in        | i_valid / o_ready  | i_action, i_node_a, i_node_b
//  result   | out       | o_valid / i_ready  | o_ancestor_node (one per query)
//
// After reset the node table is cleared one row per cycle, with o_ready low throughout.
// An add makes one dependent table read per ancestor level through RAM port A; an add
// that names the sentinel (node 0) ends after its read state and writes nothing. A query
// makes one read per level while lifting the deeper node, one per level while climbing
// both. When NODE_COUNT is below 1024, every item first has its node indices reduced
// modulo NODE_COUNT by restoring subtraction in the reduce state, before its walk starts.
// One item is in flight at a time; a finished result sits in the output register, so
// the next item is taken while it waits. A query stalls in its last state only while
// the previous result is still held.
module binary_lifting_lca #(
    parameter int NODE_COUNT  = 1024,
    parameter int JUMP_LEVELS = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic [bll_pkg::FIELD_W-1:0]   i_node_a,
    input  logic [bll_pkg::FIELD_W-1:0]   i_node_b,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bll_pkg::FIELD_W-1:0]   o_ancestor_node
);

    bll_pkg::t_dp_cmd  w_cmd;
    bll_pkg::t_dp_stat w_stat;

    // Controller: walks the clear, add and query sequences, owns both handshakes.
    bll_ctrl #(
        .NODE_COUNT  (NODE_COUNT),
        .JUMP_LEVELS (JUMP_LEVELS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_ready  (i_ready),
        .i_stat   (w_stat),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .o_cmd    (w_cmd)
    );

    // Datapath: one RAM row per node holds its depth and all its power-of-two ancestors.
    bll_dp #(
        .NODE_COUNT  (NODE_COUNT),
        .JUMP_LEVELS (JUMP_LEVELS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_node_a (i_node_a),
        .i_node_b (i_node_b),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_result (o_ancestor_node)
    );

`ifndef SYNTHESIS
    // The sentinel row is never written by an add.
    a_no_sentinel_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.op == bll_pkg::DP_ADD_WR |-> !w_stat.node_zero)
        else $error("add wrote the sentinel row");

    // A result is loaded only into a free output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.op == bll_pkg::DP_OUT |-> (!o_valid || i_ready))
        else $error("result loaded over a pending result");

    // Output valid rises only after a result load.
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.op == bll_pkg::DP_OUT))
        else $error("output valid without a result load");

    // No item is taken during the clearing pass.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.op == bll_pkg::DP_CLEAR |-> !o_ready)
        else $error("input ready during table clear");
`endif

endmodule
